// ===== rtl/scanf_integer_field_parser_defines.svh =====
// Assertion macros used by the checker file of the scanf integer field parser.
`ifndef SCANF_INTEGER_FIELD_PARSER_DEFINES_SVH
`define SCANF_INTEGER_FIELD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SIFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SIFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sifp_pkg.sv =====
// Types, constants and helper functions of the scanf integer field parser.
`default_nettype none

package sifp_pkg;

  localparam int unsigned FIELD_LIMIT_DEFAULT = 63;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FWIDTH_W   = 6;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned DIGIT_W    = 5;

  // Conversion kinds; the codes above KIND_X parse as decimal signed.
  localparam logic [KIND_W-1:0] KIND_D = 3'd0;
  localparam logic [KIND_W-1:0] KIND_I = 3'd1;
  localparam logic [KIND_W-1:0] KIND_O = 3'd2;
  localparam logic [KIND_W-1:0] KIND_U = 3'd3;
  localparam logic [KIND_W-1:0] KIND_X = 3'd4;

  typedef enum logic [0:0] {
    CFG_CONVERSION_KIND = 1'b0,
    CFG_FIELD_WIDTH     = 1'b1
  } sifp_cfg_index_t;

  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } sifp_base_t;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

  localparam logic [VALUE_W-1:0] SAT_INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_INT_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] SAT_UINT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // Field state captured when a field closes.
  typedef struct packed {
    logic [VALUE_W-1:0] magnitude;
    logic               overflow;
    logic               minus;
    logic               ok;
    logic [COUNT_W-1:0] good_count;
    logic [COUNT_W-1:0] taken_count;
    logic               char_taken;
    logic               signed_kind;
  } sifp_snap_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               parse_ok;
    logic               range_error;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] accepted_count;
    logic               char_taken;
  } sifp_result_t;

  // Digit value of a character, DIGIT_NONE when it is no hex digit.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    off = '0;
    if (c >= CH_0 && c <= CH_9) begin
      off = c - CH_0;
      return DIGIT_W'(off);
    end else if (c >= CH_LA && c <= CH_LF) begin
      off = c - CH_LA;
      return DIGIT_W'(off) + DIGIT_TEN;
    end else if (c >= CH_UA && c <= CH_UF) begin
      off = c - CH_UA;
      return DIGIT_W'(off) + DIGIT_TEN;
    end
    return DIGIT_NONE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sifp_interfaces.sv =====
// Channel interfaces of the scanf integer field parser: characters, results, configuration.
`default_nettype none

interface sifp_char_if import sifp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface sifp_result_if import sifp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               parse_ok;
  logic               range_error;
  logic [COUNT_W-1:0] used_count;
  logic [COUNT_W-1:0] accepted_count;
  logic               char_taken;

  modport source (output valid, output value, output parse_ok, output range_error,
                  output used_count, output accepted_count, output char_taken,
                  input ready);
  modport sink   (input valid, input value, input parse_ok, input range_error,
                  input used_count, input accepted_count, input char_taken,
                  output ready);
endinterface

interface sifp_cfg_if import sifp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  sifp_cfg_index_t       index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sifp_step.sv =====
// Per-character field state and its update: sign, prefix, digit shift-add, field end.
`default_nettype none

module sifp_step import sifp_pkg::*; #(
  parameter int unsigned FIELD_LIMIT = FIELD_LIMIT_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step_en,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [FWIDTH_W-1:0] field_width,
  input  wire logic [CHAR_W-1:0]   char_code,
  input  wire logic                end_of_input,
  output logic                     field_done,
  output sifp_snap_t               snap
);

  localparam int unsigned CW = $clog2(FIELD_LIMIT + 1);
  localparam int unsigned LW = (CW > FWIDTH_W) ? CW : FWIDTH_W;

  logic [VALUE_W-1:0] magnitude;
  logic               magnitude_overflow;
  sifp_base_t         base_code;
  logic               prefix_allowed;
  logic               minus_seen;
  logic [CW-1:0]      taken_count;
  logic [CW-1:0]      good_count;

  logic [VALUE_W-1:0] magnitude_next;
  logic               magnitude_overflow_next;
  sifp_base_t         base_code_next;
  logic               prefix_allowed_next;
  logic               minus_seen_next;
  logic [CW-1:0]      good_count_next;

  logic [DIGIT_W-1:0] digit;
  logic               is_sign;
  logic               is_x;
  sifp_base_t         new_code;
  sifp_base_t         base_sel;
  logic               digit_fits;
  logic [VALUE_W+3:0] scaled;
  logic [VALUE_W+3:0] mac;
  logic               mac_ovf;
  logic               accept;
  logic [LW-1:0]      fw_ext;
  logic [LW-1:0]      limit;
  logic [LW-1:0]      taken_inc;
  logic               signed_kind;

  assign digit   = digit_of(char_code);
  assign is_sign = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign is_x    = (char_code == CH_LX) || (char_code == CH_UX);
  assign signed_kind = !((kind == KIND_O) || (kind == KIND_U) || (kind == KIND_X));

  // Base detection for i: a leading 0 means octal, 1-9 decimal.
  // Other kinds leave the base code untouched.
  always_comb begin
    new_code = base_code;
    if (kind == KIND_I && base_code == BASE_NONE) begin
      if (digit == '0) begin
        new_code = BASE_OCT;
      end else if (digit < DIGIT_TEN) begin
        new_code = BASE_DEC;
      end
    end
  end

  always_comb begin
    priority if (kind == KIND_I) begin
      base_sel = new_code;
    end else if (kind == KIND_O) begin
      base_sel = BASE_OCT;
    end else if (kind == KIND_X) begin
      base_sel = BASE_HEX;
    end else begin
      base_sel = BASE_DEC;
    end
  end

  // Shift-add; a carry into the top nibble means the magnitude left 64 bits.
  always_comb begin
    unique case (base_sel)
      BASE_NONE: begin
        digit_fits = 1'b0;
        scaled     = '0;
      end
      BASE_OCT: begin
        digit_fits = digit < 5'd8;
        scaled     = {4'b0, magnitude} << 3;
      end
      BASE_DEC: begin
        digit_fits = digit < DIGIT_TEN;
        scaled     = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1);
      end
      BASE_HEX: begin
        digit_fits = digit < DIGIT_NONE;
        scaled     = {4'b0, magnitude} << 4;
      end
      default: begin
        digit_fits = 1'b0;
        scaled     = '0;
      end
    endcase
  end

  assign mac     = scaled + (VALUE_W + 4)'(digit);
  assign mac_ovf = mac[VALUE_W+3:VALUE_W] != '0;

  always_comb begin
    magnitude_next          = magnitude;
    magnitude_overflow_next = magnitude_overflow;
    base_code_next          = base_code;
    prefix_allowed_next     = prefix_allowed;
    minus_seen_next         = minus_seen;
    good_count_next         = good_count;
    accept                  = 1'b0;
    if (!end_of_input) begin
      priority if (is_sign) begin
        accept = taken_count == '0;
        if (accept && char_code == CH_MINUS) begin
          minus_seen_next = 1'b1;
        end
      end else if (is_x) begin
        accept = prefix_allowed;
        if (accept) begin
          if (kind == KIND_I) begin
            base_code_next = BASE_HEX;
          end
          prefix_allowed_next = 1'b0;
        end
      end else if (digit != DIGIT_NONE && digit_fits) begin
        accept              = 1'b1;
        base_code_next      = new_code;
        prefix_allowed_next = (digit == '0) && (good_count == '0) &&
                              ((kind == KIND_I) || (kind == KIND_X));
        if (mac_ovf) begin
          magnitude_overflow_next = 1'b1;
        end else begin
          magnitude_next = mac[VALUE_W-1:0];
        end
        good_count_next = taken_count + CW'(1);
      end else begin
        accept = 1'b0;
      end
    end
  end

  assign fw_ext    = LW'(field_width);
  assign limit     = (fw_ext == '0 || fw_ext > LW'(FIELD_LIMIT)) ? LW'(FIELD_LIMIT) : fw_ext;
  assign taken_inc = LW'(taken_count) + LW'(1);
  assign field_done = !accept || (taken_inc >= limit);

  // Rejected characters leave the state as it was, so the update covers both cases.
  always_comb begin
    snap.magnitude   = magnitude_next;
    snap.overflow    = magnitude_overflow_next;
    snap.minus       = minus_seen_next;
    snap.ok          = good_count_next != '0;
    snap.good_count  = COUNT_W'(good_count_next);
    snap.taken_count = accept ? COUNT_W'(taken_inc) : COUNT_W'(taken_count);
    snap.char_taken  = accept;
    snap.signed_kind = signed_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude          <= '0;
      magnitude_overflow <= 1'b0;
      base_code          <= BASE_NONE;
      prefix_allowed     <= 1'b0;
      minus_seen         <= 1'b0;
      taken_count        <= '0;
      good_count         <= '0;
    end else if (step_en) begin
      if (field_done) begin
        magnitude          <= '0;
        magnitude_overflow <= 1'b0;
        base_code          <= BASE_NONE;
        prefix_allowed     <= 1'b0;
        minus_seen         <= 1'b0;
        taken_count        <= '0;
        good_count         <= '0;
      end else begin
        magnitude          <= magnitude_next;
        magnitude_overflow <= magnitude_overflow_next;
        base_code          <= base_code_next;
        prefix_allowed     <= prefix_allowed_next;
        minus_seen         <= minus_seen_next;
        taken_count        <= taken_inc[CW-1:0];
        good_count         <= good_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sifp_format.sv =====
// Result formatting of a closed field: sign, saturation and counts.
`default_nettype none

module sifp_format import sifp_pkg::*; (
  input  sifp_snap_t   snap,
  output sifp_result_t result
);

  logic [VALUE_W-1:0] negated;
  logic               above_min;

  assign negated   = '0 - snap.magnitude;
  assign above_min = snap.magnitude[VALUE_W-1] && (snap.magnitude[VALUE_W-2:0] != '0);

  always_comb begin
    result.value          = '0;
    result.range_error    = 1'b0;
    result.parse_ok       = snap.ok;
    result.used_count     = snap.ok ? snap.good_count : '0;
    result.accepted_count = snap.taken_count;
    result.char_taken     = snap.char_taken;
    if (snap.ok) begin
      if (snap.signed_kind) begin
        if (snap.minus) begin
          if (snap.overflow || above_min) begin
            result.value       = SAT_INT_MIN;
            result.range_error = 1'b1;
          end else begin
            result.value = negated;
          end
        end else begin
          if (snap.overflow || snap.magnitude[VALUE_W-1]) begin
            result.value       = SAT_INT_MAX;
            result.range_error = 1'b1;
          end else begin
            result.value = snap.magnitude;
          end
        end
      end else begin
        if (snap.overflow) begin
          result.value       = SAT_UINT_MAX;
          result.range_error = 1'b1;
        end else begin
          result.value = snap.minus ? negated : snap.magnitude;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scanf_integer_field_parser.sv =====
// Top level of the scanf integer field parser: channels, config registers, pipeline.
`default_nettype none

// Usage
//   chr : one request per character (char_code), or an end-of-stream marker
//         (end_of_input = 1). A character rejected by the field is reported with
//         char_taken = 0 and must be sent again as the first character of what
//         follows; nothing is pushed back inside the block.
//   res : one request per closed field: value, parse_ok, range_error,
//         used_count, accepted_count, char_taken.
//   cfg : index 0 writes conversion_kind (data[2:0]), index 1 writes
//         field_width (data[5:0]); ready is always high. Write only while idle.
// Timing
//   Three register stages: input, field snapshot, result. The request that closes a
//   field goes from the input stage to the snapshot and then the result register, and
//   its result shows on res. While res is not stalled, one character per cycle is taken
//   back to back; the rate is set by the 64-bit shift-add of the magnitude in sifp_step.
// Reset
//   rst (synchronous) empties every stage, clears the field state and sets
//   both config registers to zero (kind d, width limit FIELD_LIMIT).
// Stall
//   While res is held, the result waits in its register; the snapshot stage
//   and the input stage still fill, then chr.ready drops.

module scanf_integer_field_parser import sifp_pkg::*; #(
  parameter int unsigned FIELD_LIMIT = FIELD_LIMIT_DEFAULT
) (
  input wire logic     clk,
  input wire logic     rst,
  sifp_char_if.sink    chr,
  sifp_result_if.source res,
  sifp_cfg_if.sink     cfg
);

  // Configuration registers
  logic [KIND_W-1:0]   conversion_kind;
  logic [FWIDTH_W-1:0] field_width;

  // Input stage
  logic              a_valid;
  logic [CHAR_W-1:0] a_char;
  logic              a_eoi;

  // Snapshot stage
  logic       b_valid;
  sifp_snap_t b_snap;

  // Result stage
  logic         c_valid;
  sifp_result_t c_result;

  logic         c_free;
  logic         b_free;
  logic         a_adv;
  logic         field_done;
  sifp_snap_t   step_snap;
  sifp_result_t fmt_result;

  // Advance a stage when the one after it is free or moving on.
  assign c_free    = !c_valid || res.ready;
  assign b_free    = !b_valid || c_free;
  assign a_adv     = a_valid && b_free;
  assign chr.ready = !a_valid || b_free;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion_kind <= KIND_D;
      field_width     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CONVERSION_KIND: conversion_kind <= cfg.data[KIND_W-1:0];
        CFG_FIELD_WIDTH:     field_width     <= cfg.data[FWIDTH_W-1:0];
        default:             conversion_kind <= conversion_kind;
      endcase
    end
  end

  // Hold the character until the step logic can consume it.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (chr.ready) begin
      a_valid <= chr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chr.ready && chr.valid) begin
      a_char <= chr.char_code;
      a_eoi  <= chr.end_of_input;
    end
  end

  sifp_step #(
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .step_en      (a_adv),
    .kind         (conversion_kind),
    .field_width  (field_width),
    .char_code    (a_char),
    .end_of_input (a_eoi),
    .field_done   (field_done),
    .snap         (step_snap)
  );

  // Capture the field only on the character that closes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_adv && field_done;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && field_done) begin
      b_snap <= step_snap;
    end
  end

  sifp_format u_format (
    .snap   (b_snap),
    .result (fmt_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && b_valid) begin
      c_result <= fmt_result;
    end
  end

  assign res.valid          = c_valid;
  assign res.value          = c_result.value;
  assign res.parse_ok       = c_result.parse_ok;
  assign res.range_error    = c_result.range_error;
  assign res.used_count     = c_result.used_count;
  assign res.accepted_count = c_result.accepted_count;
  assign res.char_taken     = c_result.char_taken;

endmodule

`default_nettype wire

// ===== rtl/sifp_checker.sv =====
// Port-level checker of the scanf integer field parser and its bind.
`default_nettype none
`include "scanf_integer_field_parser_defines.svh"

module sifp_checker import sifp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [VALUE_W-1:0] value,
  input wire logic               parse_ok,
  input wire logic               range_error,
  input wire logic [COUNT_W-1:0] used_count
);

  `SIFP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(value) && $stable(used_count), "result changed while stalled")
  `SIFP_ASSERT_NOW(a_err_needs_ok, clk, rst, res_valid && range_error, parse_ok, "range error without a parsed number")
  `SIFP_ASSERT_NOW(a_empty_field, clk, rst, res_valid && !parse_ok, value == '0 && used_count == '0, "empty field gave nonzero value or count")
  `SIFP_ASSERT_NOW(a_saturated, clk, rst, res_valid && range_error, value == SAT_INT_MAX || value == SAT_INT_MIN || value == SAT_UINT_MAX, "range error with a value that is not a limit")

endmodule

bind scanf_integer_field_parser sifp_checker u_sifp_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .value       (res.value),
  .parse_ok    (res.parse_ok),
  .range_error (res.range_error),
  .used_count  (res.used_count)
);

`default_nettype wire

// ===== bench/tb_scanf_integer_field_parser.sv =====
`timescale 1ns / 100ps
// Testbench of the scanf integer field parser: character streams checked against a field predictor.

module tb_scanf_integer_field_parser;
  import sifp_pkg::*;

  localparam int unsigned FIELD_MAX     = FIELD_LIMIT_DEFAULT;
  localparam logic [4:0]  NOT_A_DIGIT   = 5'd31;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_CHARS   = 90;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned SETTLE_CYCLES = 4;

  // One request on the character channel.
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              at_end;
  } char_req_t;

  // Receiver behavior, rotated through the modes below.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // Field predictor plus the queue of results it expects from the block.
  class field_scoreboard;
    logic [KIND_W-1:0]   conv_kind;
    logic [FWIDTH_W-1:0] width_reg;
    logic [VALUE_W-1:0]  magnitude;
    logic                wrapped;
    sifp_base_t          base_sel;
    logic                prefix_ok;
    logic                negative;
    int unsigned         taken;
    int unsigned         good;
    sifp_result_t        expected_fields[$];
    int unsigned         failures;

    function new();
      conv_kind = '0;
      width_reg = '0;
      failures  = 0;
      clear_field();
    endfunction

    function void clear_field();
      magnitude = '0;
      wrapped   = 1'b0;
      base_sel  = BASE_NONE;
      prefix_ok = 1'b0;
      negative  = 1'b0;
      taken     = 0;
      good      = 0;
    endfunction

    function void set_reg(sifp_cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CONVERSION_KIND) begin
        conv_kind = data[KIND_W-1:0];
      end else begin
        width_reg = data[FWIDTH_W-1:0];
      end
    endfunction

    // Fold the letter case so one range test covers a-f and A-F.
    function logic [4:0] hex_value(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] folded;
      folded = c | 8'h20;
      if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
      if (folded >= CH_LA && folded <= CH_LF) return 5'(folded - CH_LA) + 5'd10;
      return NOT_A_DIGIT;
    endfunction

    // Close the field: saturate per signedness and queue the expected result.
    function void close_field(logic took);
      sifp_result_t r;
      logic         is_signed;
      r = '0;
      is_signed = !(conv_kind == KIND_O || conv_kind == KIND_U || conv_kind == KIND_X);
      if (good > 0) begin
        r.parse_ok   = 1'b1;
        r.used_count = COUNT_W'(good);
        if (is_signed && negative) begin
          if (wrapped || magnitude > SAT_INT_MIN) begin
            r.value       = SAT_INT_MIN;
            r.range_error = 1'b1;
          end else begin
            r.value = -magnitude;
          end
        end else if (is_signed) begin
          if (wrapped || magnitude > SAT_INT_MAX) begin
            r.value       = SAT_INT_MAX;
            r.range_error = 1'b1;
          end else begin
            r.value = magnitude;
          end
        end else if (wrapped) begin
          r.value       = SAT_UINT_MAX;
          r.range_error = 1'b1;
        end else begin
          r.value = negative ? -magnitude : magnitude;
        end
      end
      r.accepted_count = COUNT_W'(taken);
      r.char_taken     = took;
      expected_fields.push_back(r);
      clear_field();
    endfunction

    // Advance the field by one accepted request.
    function void note_request(char_req_t req);
      logic [4:0]     d;
      int unsigned    radix;
      int unsigned    limit;
      sifp_base_t     next_base;
      logic           take;
      logic [VALUE_W+3:0] grown;
      limit = (width_reg == 0 || width_reg > FIELD_MAX) ? FIELD_MAX : width_reg;
      take  = 1'b0;
      if (req.at_end) begin
        close_field(1'b0);
        return;
      end
      if (req.code == CH_PLUS || req.code == CH_MINUS) begin
        take = (taken == 0);
        if (take && req.code == CH_MINUS) negative = 1'b1;
      end else if (req.code == CH_LX || req.code == CH_UX) begin
        take = prefix_ok;
        if (take) begin
          if (conv_kind == KIND_I) base_sel = BASE_HEX;
          prefix_ok = 1'b0;
        end
      end else begin
        d = hex_value(req.code);
        if (d != NOT_A_DIGIT) begin
          next_base = base_sel;
          case (conv_kind)
            KIND_I: begin
              // auto base: the first digit picks octal or decimal
              if (base_sel == BASE_NONE && d == 0) begin
                next_base = BASE_OCT;
              end else if (base_sel == BASE_NONE && d < 10) begin
                next_base = BASE_DEC;
              end
              case (next_base)
                BASE_OCT: radix = 8;
                BASE_DEC: radix = 10;
                BASE_HEX: radix = 16;
                default:  radix = 0;
              endcase
            end
            KIND_O:  radix = 8;
            KIND_X:  radix = 16;
            default: radix = 10;
          endcase
          take = (radix != 0 && d < radix);
          if (take) begin
            base_sel  = next_base;
            prefix_ok = (d == 0 && good == 0 && (conv_kind == KIND_I || conv_kind == KIND_X));
            grown = {4'b0, magnitude} * (VALUE_W+4)'(radix) + (VALUE_W+4)'(d);
            if (grown[VALUE_W+3:VALUE_W] != 0) begin
              wrapped = 1'b1;
            end else begin
              magnitude = grown[VALUE_W-1:0];
            end
            good = taken + 1;
          end
        end
      end
      if (!take) begin
        close_field(1'b0);
        return;
      end
      taken++;
      if (taken >= limit) close_field(1'b1);
    endfunction

    function void check_result(sifp_result_t got);
      sifp_result_t want;
      if (expected_fields.size() == 0) begin
        $error("result with no field pending: value %h", got.value);
        failures++;
        return;
      end
      want = expected_fields.pop_front();
      if (got.value != want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        failures++;
      end
      if (got.parse_ok != want.parse_ok) begin
        $error("parse_ok: expected %0d, got %0d", want.parse_ok, got.parse_ok);
        failures++;
      end
      if (got.range_error != want.range_error) begin
        $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
        failures++;
      end
      if (got.used_count != want.used_count) begin
        $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
        failures++;
      end
      if (got.accepted_count != want.accepted_count) begin
        $error("accepted_count: expected %0d, got %0d",
               want.accepted_count, got.accepted_count);
        failures++;
      end
      if (got.char_taken != want.char_taken) begin
        $error("char_taken: expected %0d, got %0d", want.char_taken, got.char_taken);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  sifp_char_if   chr ();
  sifp_result_if res ();
  sifp_cfg_if    cfg ();

  field_scoreboard fields = new();
  char_req_t       char_stream[$];
  sifp_result_t    seen_result;
  logic            start_long_hold = 1'b0;
  logic            long_hold_done;
  int unsigned     hold_left;
  int unsigned     rx_cycle;
  int unsigned     cycle_count = 0;

  scanf_integer_field_parser u_dut (
    .clk (clk),
    .rst (rst),
    .chr (chr),
    .res (res),
    .cfg (cfg)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: rotate between open, light, heavy and periodic stalls.
  // One long hold-off on request lets the block fill up and drop chr.ready.
  always @(posedge clk) begin
    if (rst) begin
      res.ready      <= 1'b0;
      rx_cycle       <= 0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (start_long_hold && !long_hold_done) begin
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
        res.ready      <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        case (rx_mode_t'((rx_cycle / 300) % 4))
          RX_OPEN:  res.ready <= 1'b1;
          RX_LIGHT: res.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: res.ready <= ($urandom_range(0, 4) == 0);
          default:  res.ready <= ((rx_cycle % 6) < 2);
        endcase
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      seen_result.value          = res.value;
      seen_result.parse_ok       = res.parse_ok;
      seen_result.range_error    = res.range_error;
      seen_result.used_count     = res.used_count;
      seen_result.accepted_count = res.accepted_count;
      seen_result.char_taken     = res.char_taken;
      fields.check_result(seen_result);
    end
  end

  task automatic push_char(logic [CHAR_W-1:0] c);
    char_stream.push_back('{code: c, at_end: 1'b0});
  endtask

  task automatic push_end();
    char_stream.push_back('{code: 8'($urandom_range(0, 255)), at_end: 1'b1});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_prefix();
    push_char(CH_0);
    push_char(($urandom_range(0, 1) != 0) ? CH_LX : CH_UX);
  endtask

  // Append one plausible field: sign, prefix, digits of the base, terminator.
  task automatic add_field(logic [KIND_W-1:0] kind);
    int unsigned radix;
    int unsigned ndig;
    int unsigned pick;
    int unsigned dv;
    radix = 10;
    pick  = $urandom_range(0, 9);
    if (pick < 2) begin
      push_char(CH_MINUS);
    end else if (pick < 3) begin
      push_char(CH_PLUS);
    end
    case (kind)
      KIND_O: radix = 8;
      KIND_X: begin
        radix = 16;
        if ($urandom_range(0, 2) == 0) push_prefix();
      end
      KIND_I: begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          radix = 16;
          push_prefix();
        end else if (pick == 1) begin
          radix = 8;
          push_char(CH_0);
        end
      end
      default: radix = 10;
    endcase
    // mostly short numbers, some long enough to saturate
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      ndig = 0;
    end else if (pick < 4) begin
      ndig = $urandom_range(16, 26);
    end else begin
      ndig = $urandom_range(1, 6);
    end
    for (int i = 0; i < ndig; i++) begin
      dv = $urandom_range(0, radix - 1);
      if (i == 0 && kind == KIND_I && radix == 10 && dv == 0) dv = $urandom_range(1, 9);
      if (dv < 10) begin
        push_char(CH_0 + 8'(dv));
      end else begin
        push_char((($urandom_range(0, 1) != 0) ? CH_UA : CH_LA) + 8'(dv - 10));
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      push_end();
    end else if (pick < 7) begin
      push_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(sifp_cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    fields.set_reg(idx, data);
    cfg.valid <= 1'b0;
  endtask

  task automatic configure(logic [KIND_W-1:0] kind, logic [FWIDTH_W-1:0] width);
    write_reg(CFG_CONVERSION_KIND, CFG_DATA_W'(kind));
    write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'(width));
  endtask

  // Offer the queued requests in bursts with random gaps; hold while stalled.
  task automatic send_stream();
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap_left;
    bit          may_idle;
    idx        = 0;
    gap_left   = 0;
    burst_left = $urandom_range(1, 24);
    may_idle   = ($urandom_range(0, 2) != 0);
    while (idx < char_stream.size()) begin
      @(posedge clk);
      if (chr.valid && chr.ready) begin
        fields.note_request(char_stream[idx]);
        idx++;
      end
      if (idx == char_stream.size()) begin
        chr.valid <= 1'b0;
      end else if (!chr.valid || chr.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          chr.valid <= 1'b0;
        end else begin
          chr.valid        <= 1'b1;
          chr.char_code    <= char_stream[idx].code;
          chr.end_of_input <= char_stream[idx].at_end;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = may_idle ? $urandom_range(1, 8) : 0;
          end
        end
      end
    end
    char_stream.delete();
  endtask

  // Wait until every expected field has come back, then let the pipe settle.
  task automatic drain();
    while (fields.expected_fields.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [KIND_W-1:0] kind, logic [FWIDTH_W-1:0] width, bit hold_off);
    configure(kind, width);
    while (char_stream.size() < PHASE_CHARS) begin
      // every so often drop in raw bytes and stray stream ends
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) push_end();
      end else begin
        add_field(kind);
      end
    end
    push_end();
    if (hold_off) start_long_hold <= 1'b1;
    send_stream();
    drain();
  endtask

  initial begin
    logic [KIND_W-1:0]   kind;
    logic [FWIDTH_W-1:0] width;
    int unsigned         pick;

    // Every input known from time zero; the stimulus takes over after reset.
    chr.valid        = 1'b0;
    chr.char_code    = '0;
    chr.end_of_input = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = CFG_CONVERSION_KIND;
    cfg.data         = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: signs, rejected bytes at both ends of the code range, no digit.
    configure(KIND_D, 6'd0);
    push_text("+7");
    push_char(8'hFF);
    push_char(8'h00);
    push_char(CH_MINUS);
    push_end();
    send_stream();
    drain();

    // Minus on an unsigned kind wraps the magnitude.
    configure(KIND_U, 6'd0);
    push_text("-1");
    push_end();
    send_stream();
    drain();

    // Hex prefix cut by a width of three, then the rest as a new field.
    configure(KIND_X, 6'd3);
    push_text("0x1f");
    push_end();
    send_stream();
    drain();

    // Auto base: 0x with no hex digit counts only its 0; 9 is no octal digit.
    configure(KIND_I, 6'd0);
    push_text("0x");
    push_end();
    push_text("09");
    push_end();
    send_stream();
    drain();

    // Codes above x parse as signed decimal.
    configure(3'd7, 6'd63);
    push_text("-12");
    push_end();
    send_stream();
    drain();

    // Width of one; 8 is no octal digit.
    configure(KIND_O, 6'd1);
    push_text("78");
    push_end();
    send_stream();
    drain();

    // Saturation: seventeen hex digits overflow 64 bits.
    configure(KIND_X, 6'd0);
    push_text("FFFFFFFFFFFFFFFFF");
    push_end();
    send_stream();
    drain();

    // Random phases under changing settings, extremes first.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          kind  = KIND_X;
          width = 6'd63;
        end
        1: begin
          kind  = KIND_I;
          width = 6'd1;
        end
        2: begin
          kind  = KIND_O;
          width = 6'd0;
        end
        default: begin
          kind = ($urandom_range(0, 9) < 8) ? KIND_W'($urandom_range(0, 4))
                                            : KIND_W'($urandom_range(5, 7));
          pick = $urandom_range(0, 5);
          if (pick == 0) begin
            width = 6'd0;
          end else if (pick == 1) begin
            width = 6'd1;
          end else if (pick == 2) begin
            width = 6'd63;
          end else begin
            width = FWIDTH_W'($urandom_range(2, 20));
          end
        end
      endcase
      run_phase(kind, width, p == 3);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fields.failures == 0 && fields.expected_fields.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== scanf_integer_field_parser.f =====
+incdir+rtl
rtl/sifp_pkg.sv
rtl/sifp_interfaces.sv
rtl/sifp_step.sv
rtl/sifp_format.sv
rtl/scanf_integer_field_parser.sv
rtl/sifp_checker.sv
bench/tb_scanf_integer_field_parser.sv
